>>> rtl/jsu_pkg.sv
package jsu_pkg;

	// Decoder phase within one quoted string literal.
	typedef enum logic [1:0] {
		PH_QUOTE = 2'd0,
		PH_BODY  = 2'd1,
		PH_ESC   = 2'd2,
		PH_HEX   = 2'd3
	} phase_t;

	// Kinds of result word.
	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_N  = 8'h6E;
	localparam logic [7:0] CH_LC_R  = 8'h72;
	localparam logic [7:0] CH_LC_T  = 8'h74;
	localparam logic [7:0] CH_LC_U  = 8'h75;
	localparam logic [15:0] ASCII_MAX = 16'h007F;

	// Hex digit decode: bit 4 set means the byte is a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

>>> rtl/json_string_unescape_top.sv
// Path: a byte accepted from s_tdata is held in the input register, and its
// result word, if it makes one, is then loaded into the result register.
// Throughput: one byte per cycle, set by the single decode step between the
// input register and the result register; stalls only follow m_tready.
// Reset: arst_n clears both register valids and the decoder state to
// "expect opening quote" with an empty hex accumulator.
module json_string_unescape_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] decoded_byte
	output logic [1:0] m_tuser    // [1:0] result_kind
);
	import jsu_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	phase_t      phase_q, phase_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [15:0] acc_q, acc_d;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	kind_t       out_kind_q;
	logic        advance;
	logic        res_valid;
	logic [7:0]  res_byte;
	kind_t       res_kind;
	logic [4:0]  hexv;
	logic [15:0] acc_new;

	// The held word moves on when the result register is free or draining.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign hexv     = hex_value(byte_s1);
	assign acc_new  = {acc_q[11:0], hexv[3:0]};

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// Next state of the decoder.
	always_comb begin
		phase_d   = phase_q;
		hex_cnt_d = hex_cnt_q;
		acc_d     = acc_q;
		unique case (phase_q)
			PH_QUOTE: begin
				if (byte_s1 == CH_QUOTE) phase_d = PH_BODY;
			end
			PH_BODY: begin
				if (byte_s1 == CH_BSL) begin
					phase_d = PH_ESC;
				end else if (byte_s1 < CH_SPACE || byte_s1 == CH_QUOTE) begin
					phase_d = PH_QUOTE;
				end
			end
			PH_ESC: begin
				unique case (byte_s1)
					CH_QUOTE, CH_BSL, CH_SLASH, CH_LC_B, CH_LC_F,
					CH_LC_N, CH_LC_R, CH_LC_T: phase_d = PH_BODY;
					CH_LC_U: begin
						phase_d   = PH_HEX;
						hex_cnt_d = 2'd0;
						acc_d     = 16'd0;
					end
					default: phase_d = PH_QUOTE;
				endcase
			end
			PH_HEX: begin
				if (!hexv[4]) begin
					phase_d = PH_QUOTE;
				end else if (hex_cnt_q == 2'd3) begin
					phase_d = PH_BODY;
				end else begin
					hex_cnt_d = hex_cnt_q + 2'd1;
					acc_d     = acc_new;
				end
			end
			default: phase_d = PH_QUOTE;
		endcase
		// Leaving a string or finishing an escape clears the counters.
		if (phase_d == PH_QUOTE || (phase_q == PH_HEX && phase_d == PH_BODY)) begin
			hex_cnt_d = 2'd0;
			acc_d     = 16'd0;
		end
	end

	// Result word produced by the held byte.
	always_comb begin
		res_valid = 1'b1;
		res_byte  = 8'd0;
		res_kind  = KIND_ERROR;
		unique case (phase_q)
			PH_QUOTE: begin
				if (byte_s1 == CH_QUOTE) res_valid = 1'b0;
			end
			PH_BODY: begin
				if (byte_s1 == CH_QUOTE) begin
					res_kind = KIND_DONE;
				end else if (byte_s1 == CH_BSL) begin
					res_valid = 1'b0;
				end else if (byte_s1 >= CH_SPACE) begin
					res_kind = KIND_CHAR;
					res_byte = byte_s1;
				end
			end
			PH_ESC: begin
				res_kind = KIND_CHAR;
				unique case (byte_s1)
					CH_QUOTE, CH_BSL, CH_SLASH: res_byte = byte_s1;
					CH_LC_B: res_byte = 8'h08;
					CH_LC_F: res_byte = 8'h0C;
					CH_LC_N: res_byte = 8'h0A;
					CH_LC_R: res_byte = 8'h0D;
					CH_LC_T: res_byte = 8'h09;
					CH_LC_U: res_valid = 1'b0;
					default: res_kind = KIND_ERROR;
				endcase
			end
			PH_HEX: begin
				if (hexv[4]) begin
					if (hex_cnt_q == 2'd3) begin
						res_kind = KIND_CHAR;
						res_byte = (acc_new <= ASCII_MAX) ? acc_new[7:0] : CH_QMARK;
					end else begin
						res_valid = 1'b0;
					end
				end
			end
			default: res_valid = 1'b1;
		endcase
	end

	// Decoder state, updated as each byte is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_QUOTE;
			hex_cnt_q <= 2'd0;
			acc_q     <= 16'd0;
		end else if (advance) begin
			phase_q   <= phase_d;
			hex_cnt_q <= hex_cnt_d;
			acc_q     <= acc_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_byte_q <= res_byte;
			out_kind_q <= res_kind;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_kind_q;

endmodule
